// ===== rtl/sirl_pkg.sv =====
// ----------------------------------------------------------------------------
// sirl_pkg: shared types and constants for the shifting insert/remove list
// Capacity, field widths, function codes and the command broadcast to cells.
// ----------------------------------------------------------------------------
package sirl_pkg;

    localparam int CAPACITY  = 128;
    localparam int DATA_W    = 32;
    localparam int FUNC_W    = 3;
    localparam int POS_W     = 7;
    localparam int OUT_CNT_W = 8;
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    // compare width covers the count, a position and the 8-bit count port
    localparam int CMP_W     = (CNT_W > OUT_CNT_W) ? CNT_W : OUT_CNT_W;
    // read taps are or-ed in groups, then the group results
    localparam int GROUP     = 16;
    localparam int NGRP      = (CAPACITY + GROUP - 1) / GROUP;

    typedef logic [DATA_W-1:0] t_word;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_APPEND = 3'd0,
        FUNC_INSERT = 3'd1,
        FUNC_REMOVE = 3'd2,
        FUNC_GET    = 3'd3,
        FUNC_CLEAR  = 3'd4
    } t_func;

    typedef struct packed {
        logic             ins;
        logic             rem;
        logic             rd;
        logic [CMP_W-1:0] pos;
        t_word            value;
    } t_cell_cmd;

endpackage

// ===== rtl/sirl_cell.sv =====
// ----------------------------------------------------------------------------
// sirl_cell: one list entry
// Holds one word; loads the new word, takes its lower or upper neighbor on a
// shift, and drives its word onto a read tap when addressed.
// ----------------------------------------------------------------------------
module sirl_cell (
    input  logic                        i_clk,
    input  sirl_pkg::t_cell_cmd         i_cmd,
    input  logic [sirl_pkg::CMP_W-1:0]  i_index,
    input  sirl_pkg::t_word             i_left,
    input  sirl_pkg::t_word             i_right,
    output sirl_pkg::t_word             o_entry,
    output sirl_pkg::t_word             o_tap
);
    import sirl_pkg::*;

    t_word r_entry;
    t_word n_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_cmd.ins) begin
            if (i_index == i_cmd.pos) begin
                n_entry = i_cmd.value;
            end else if (i_index > i_cmd.pos) begin
                n_entry = i_left;
            end
        end else if (i_cmd.rem && (i_index >= i_cmd.pos)) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    // tap shows the word before this cycle's shift
    assign o_tap   = (i_cmd.rd && (i_index == i_cmd.pos)) ? r_entry : '0;
    assign o_entry = r_entry;

endmodule

// ===== rtl/sirl_read_tree.sv =====
// ----------------------------------------------------------------------------
// sirl_read_tree: registered or-tree over the cell read taps
// At most one tap is nonzero; two register levels give the read word.
// ----------------------------------------------------------------------------
module sirl_read_tree (
    input  logic            i_clk,
    input  sirl_pkg::t_word i_tap [sirl_pkg::CAPACITY],
    output sirl_pkg::t_word o_data
);
    import sirl_pkg::*;

    t_word r_grp [NGRP];
    t_word n_grp [NGRP];
    t_word r_data;
    t_word n_data;

    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            n_grp[g] = '0;
            for (int k = 0; k < GROUP; k++) begin
                if (g * GROUP + k < CAPACITY) begin
                    n_grp[g] = n_grp[g] | i_tap[g * GROUP + k];
                end
            end
        end
    end

    always_comb begin
        n_data = '0;
        for (int g = 0; g < NGRP; g++) begin
            n_data = n_data | r_grp[g];
        end
    end

    always_ff @(posedge i_clk) begin
        r_grp  <= n_grp;
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

// ===== rtl/shifting_insert_remove_list.sv =====
// ----------------------------------------------------------------------------
// shifting_insert_remove_list: ordered list of 32-bit words with a count
// Row of entry cells that shift up on insert and down on remove.
// ----------------------------------------------------------------------------
// Usage:
//   A request (i_func, i_position, i_value) is taken at a rising edge with
//   start high and busy low. busy never rises: every cell shifts in the
//   same cycle, so a new request may follow in every cycle.
//   Functions: append, insert at position, remove at position, get, clear.
//   Each request gives one result word on o_read_value, o_entry_count and
//   o_error, marked by o_valid for exactly one cycle.
//   The result word passes through the two register levels of the read
//   or-tree over the cell taps.
//   Throughput: one request per cycle.
//   The list state is updated at the accepting edge, so a request sees all
//   earlier ones even while their results are still in flight.
//   A rejected request (full list, position out of range, unknown function)
//   sets o_error, returns zero and changes nothing.
//   Reset empties the list and drops results in flight; the entry words are
//   not cleared and are only read after being written.
//   The receiver cannot stall; results are not held.
// ----------------------------------------------------------------------------
module shifting_insert_remove_list (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [sirl_pkg::FUNC_W-1:0]    i_func,
    input  logic [sirl_pkg::POS_W-1:0]     i_position,
    input  logic [sirl_pkg::DATA_W-1:0]    i_value,
    output logic                           o_valid,
    output logic [sirl_pkg::DATA_W-1:0]    o_read_value,
    output logic [sirl_pkg::OUT_CNT_W-1:0] o_entry_count,
    output logic                           o_error
);
    import sirl_pkg::*;

    logic             acc;
    t_func            func;
    logic [CMP_W-1:0] pos_x;
    logic             full;
    logic             err;
    logic             ins;
    logic             rem;
    logic             rd;
    logic [CMP_W-1:0] ins_pos;
    logic [CMP_W-1:0] n_count;
    logic [CMP_W-1:0] r_count;
    t_cell_cmd        cmd;

    logic             r_s1_vld;
    logic             r_s1_err;
    logic [CMP_W-1:0] r_s1_cnt;
    logic             r_out_vld;
    logic             r_out_err;
    logic [CMP_W-1:0] r_out_cnt;

    t_word entry [CAPACITY];
    t_word tap   [CAPACITY];
    t_word rd_data;

    assign busy  = 1'b0;
    assign acc   = start && !busy;
    assign func  = t_func'(i_func);
    assign pos_x = CMP_W'(i_position);
    assign full  = (r_count == CMP_W'(CAPACITY));

    always_comb begin
        err     = 1'b0;
        ins     = 1'b0;
        rem     = 1'b0;
        rd      = 1'b0;
        ins_pos = pos_x;
        n_count = r_count;
        unique case (func)
            FUNC_APPEND: begin
                if (full) begin
                    err = 1'b1;
                end else begin
                    ins     = 1'b1;
                    ins_pos = r_count;
                    n_count = r_count + 1'b1;
                end
            end
            FUNC_INSERT: begin
                if (full || (pos_x > r_count)) begin
                    err = 1'b1;
                end else begin
                    ins     = 1'b1;
                    n_count = r_count + 1'b1;
                end
            end
            FUNC_REMOVE: begin
                if (pos_x >= r_count) begin
                    err = 1'b1;
                end else begin
                    rem     = 1'b1;
                    rd      = 1'b1;
                    n_count = r_count - 1'b1;
                end
            end
            FUNC_GET: begin
                if (pos_x >= r_count) begin
                    err = 1'b1;
                end else begin
                    rd = 1'b1;
                end
            end
            FUNC_CLEAR: begin
                n_count = '0;
            end
            default: begin
                err = 1'b1;
            end
        endcase
    end

    assign cmd.ins   = acc && ins;
    assign cmd.rem   = acc && rem;
    assign cmd.rd    = acc && rd;
    assign cmd.pos   = ins_pos;
    assign cmd.value = i_value;

    for (genvar c = 0; c < CAPACITY; c++) begin : g_cell
        sirl_cell u_cell (
            .i_clk   (i_clk),
            .i_cmd   (cmd),
            .i_index (CMP_W'(c)),
            .i_left  ((c == 0) ? i_value : entry[(c == 0) ? 0 : c - 1]),
            .i_right ((c == CAPACITY - 1) ? '0 : entry[(c == CAPACITY - 1) ? c : c + 1]),
            .o_entry (entry[c]),
            .o_tap   (tap[c])
        );
    end

    sirl_read_tree u_read_tree (
        .i_clk  (i_clk),
        .i_tap  (tap),
        .o_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (acc) begin
                r_count <= n_count;
            end
            r_s1_vld  <= acc;
            r_out_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_err  <= err;
        r_s1_cnt  <= n_count;
        r_out_err <= r_s1_err;
        r_out_cnt <= r_s1_cnt;
    end

    assign o_valid       = r_out_vld;
    assign o_read_value  = rd_data;
    assign o_entry_count = r_out_cnt[OUT_CNT_W-1:0];
    assign o_error       = r_out_err;

endmodule

// ===== rtl/sirl_checker.sv =====
// ----------------------------------------------------------------------------
// sirl_checker: port-level checks for the shifting insert/remove list
// Watches request and result ports over time; bound to the top level.
// ----------------------------------------------------------------------------
module sirl_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           start,
    input logic                           busy,
    input logic [sirl_pkg::FUNC_W-1:0]    i_func,
    input logic                           o_valid,
    input logic [sirl_pkg::DATA_W-1:0]    o_read_value,
    input logic [sirl_pkg::OUT_CNT_W-1:0] o_entry_count,
    input logic                           o_error
);
    import sirl_pkg::*;

    // every accepted request is followed by a result
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##2 o_valid)
        else $error("missing result for accepted request");

    // no result without a request
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && $past(i_rst_n, 2)) |-> $past(start && !busy, 2))
        else $error("result without request");

    // a rejected request returns a zero word
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_error) |-> (o_read_value == '0))
        else $error("nonzero read word on error");

    // clear always leaves an empty list without error
    a_clear_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_func == FUNC_CLEAR)) |-> ##2
            (o_valid && (o_entry_count == '0) && !o_error))
        else $error("clear did not empty the list");

endmodule

bind shifting_insert_remove_list sirl_checker u_sirl_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .i_func        (i_func),
    .o_valid       (o_valid),
    .o_read_value  (o_read_value),
    .o_entry_count (o_entry_count),
    .o_error       (o_error)
);

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench for shifting_insert_remove_list
// Drives list requests through the command port with random gaps and checks
// every result word against a shadow copy of the list kept in the bench.
// ----------------------------------------------------------------------------
module tb;
    import sirl_pkg::*;

    localparam int TOTAL_WORDS = 1270;
    localparam int QUIET_LIMIT = 2000;
    localparam int TAIL_CYCLES = 8;
    localparam int MAX_POS     = (1 << POS_W) - 1;

    typedef struct {
        logic [FUNC_W-1:0] func;
        logic [POS_W-1:0]  position;
        t_word             value;
        bit                hold;
        bit                no_gap;
    } t_request;

    typedef struct {
        t_word                read_value;
        logic [OUT_CNT_W-1:0] entry_count;
        logic                 error;
        longint               stamp;
    } t_reply;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [FUNC_W-1:0]    i_func = '0;
    logic [POS_W-1:0]     i_position = '0;
    logic [DATA_W-1:0]    i_value = '0;
    logic                 o_valid;
    logic [DATA_W-1:0]    o_read_value;
    logic [OUT_CNT_W-1:0] o_entry_count;
    logic                 o_error;

    t_request requests_q[$];
    t_reply   replies_due[$];
    t_word    list_words[CAPACITY];
    int       list_len = 0;
    int       plan_len = 0;
    int       made = 0;
    bit       steady = 1'b0;
    int       mismatches = 0;
    int       quiet_cycles = 0;
    bit       timed_out = 1'b0;

    shifting_insert_remove_list dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_func        (i_func),
        .i_position    (i_position),
        .i_value       (i_value),
        .o_valid       (o_valid),
        .o_read_value  (o_read_value),
        .o_entry_count (o_entry_count),
        .o_error       (o_error)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // shadow list: applies one request and returns the reply it must give
    function automatic t_reply list_step(logic [FUNC_W-1:0] func, logic [POS_W-1:0] pos,
                                         t_word value);
        t_reply r;
        int     p;
        r.read_value = '0;
        r.error = 1'b0;
        p = int'(pos);
        case (func)
            FUNC_APPEND: begin
                if (list_len >= CAPACITY) begin
                    r.error = 1'b1;
                end else begin
                    list_words[list_len] = value;
                    list_len++;
                end
            end
            FUNC_INSERT: begin
                if (list_len >= CAPACITY || p > list_len) begin
                    r.error = 1'b1;
                end else begin
                    for (int i = list_len; i > p; i--)
                        list_words[i] = list_words[i - 1];
                    list_words[p] = value;
                    list_len++;
                end
            end
            FUNC_REMOVE: begin
                if (p >= list_len) begin
                    r.error = 1'b1;
                end else begin
                    r.read_value = list_words[p];
                    for (int i = p; i + 1 < list_len; i++)
                        list_words[i] = list_words[i + 1];
                    list_len--;
                end
            end
            FUNC_GET: begin
                if (p >= list_len)
                    r.error = 1'b1;
                else
                    r.read_value = list_words[p];
            end
            FUNC_CLEAR: list_len = 0;
            default:    r.error = 1'b1;
        endcase
        r.entry_count = OUT_CNT_W'(list_len);
        r.stamp = $time;
        return r;
    endfunction

    function automatic t_word rand_word();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic int pos_upto(int n);
        return $urandom_range(0, (n > MAX_POS) ? MAX_POS : n);
    endfunction

    // queue one word; plan_len tracks the count the generator expects
    task automatic add_request(logic [FUNC_W-1:0] f, int p, t_word v);
        t_request r;
        r.func = f;
        r.position = POS_W'(p);
        r.value = v;
        r.hold = 1'b0;
        r.no_gap = steady;
        case (f)
            FUNC_APPEND: if (plan_len < CAPACITY) plan_len++;
            FUNC_INSERT: if (plan_len < CAPACITY && p <= plan_len) plan_len++;
            FUNC_REMOVE: if (p < plan_len) plan_len--;
            FUNC_CLEAR:  plan_len = 0;
            default: ;
        endcase
        requests_q.push_back(r);
        made++;
    endtask

    task automatic add_hold();
        t_request r;
        r.func = '0;
        r.position = '0;
        r.value = '0;
        r.hold = 1'b1;
        r.no_gap = 1'b0;
        requests_q.push_back(r);
    endtask

    task automatic report_mismatch(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
        mismatches++;
        $display("mismatch %s: got %h, expected %h at %0t", what, got, want, $time);
    endtask

    // driver
    always @(posedge i_clk) begin
        t_request nxt;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy)
                replies_due.push_back(list_step(i_func, i_position, i_value));
            if (!start || !busy) begin
                if (requests_q.size() == 0) begin
                    start <= 1'b0;
                end else if (requests_q[0].hold) begin
                    // hold off until every word in flight has come back
                    start <= 1'b0;
                    if (replies_due.size() == 0)
                        void'(requests_q.pop_front());
                end else if (!requests_q[0].no_gap && $urandom_range(0, 99) < 35) begin
                    start <= 1'b0;
                end else begin
                    nxt = requests_q.pop_front();
                    start <= 1'b1;
                    i_func <= nxt.func;
                    i_position <= nxt.position;
                    i_value <= nxt.value;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_reply want;
        if (i_rst_n && o_valid === 1'b1) begin
            if (replies_due.size() == 0 || replies_due[0].stamp == $time) begin
                report_mismatch("unexpected word", o_read_value, '0);
            end else begin
                want = replies_due.pop_front();
                if (o_read_value !== want.read_value)
                    report_mismatch("read_value", o_read_value, want.read_value);
                if (o_entry_count !== want.entry_count)
                    report_mismatch("entry_count", DATA_W'(o_entry_count),
                                    DATA_W'(want.entry_count));
                if (o_error !== want.error)
                    report_mismatch("error", DATA_W'(o_error), DATA_W'(want.error));
            end
        end
    end

    // watchdog on cycles with no word moving either way
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid === 1'b1)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
            timed_out <= 1'b1;
    end

    initial begin
        int    mode;
        int    len;
        int    pick;

        // directed: empty list, ends of the list, bad functions, clear
        add_request(FUNC_GET, 0, '0);
        add_request(FUNC_REMOVE, 0, '0);
        add_request(FUNC_INSERT, 1, 32'h1234_5678);
        add_request(FUNC_INSERT, 0, '1);
        add_request(FUNC_APPEND, 0, '0);
        add_request(FUNC_APPEND, 0, 32'hA5A5_A5A5);
        add_request(FUNC_INSERT, 1, 32'h5A5A_5A5A);
        add_request(FUNC_INSERT, 4, 32'h0000_0001);
        add_request(FUNC_INSERT, 6, 32'h8000_0000);
        add_request(FUNC_GET, 0, '1);
        add_request(FUNC_GET, 4, '0);
        add_request(FUNC_GET, 5, '0);
        add_request(FUNC_GET, MAX_POS, '0);
        add_request(FUNC_REMOVE, 2, '0);
        add_request(FUNC_REMOVE, 3, '0);
        add_request(FUNC_REMOVE, 3, '0);
        add_request(FUNC_REMOVE, 0, '1);
        add_request(3'd5, 0, '0);
        add_request(3'd6, 1, 32'hFFFF_0000);
        add_request(3'd7, MAX_POS, '1);
        add_request(FUNC_CLEAR, MAX_POS, '1);
        add_request(FUNC_GET, 0, '0);
        add_request(FUNC_APPEND, 0, 32'hDEAD_BEEF);
        add_request(FUNC_GET, 0, '0);
        add_hold();

        while (made < TOTAL_WORDS) begin
            steady = (made >= 500 && made < 750);
            mode = $urandom_range(0, 9);
            if (mode == 0) begin
                // fill to capacity, then push against the full list
                while (plan_len < CAPACITY)
                    add_request(FUNC_APPEND, 0, rand_word());
                repeat ($urandom_range(2, 6)) begin
                    if ($urandom_range(0, 1))
                        add_request(FUNC_APPEND, 0, rand_word());
                    else
                        add_request(FUNC_INSERT, pos_upto(plan_len), rand_word());
                end
                add_request(FUNC_GET, MAX_POS, '0);
            end else if (mode <= 3) begin
                len = $urandom_range(20, 120);
                repeat (len) begin
                    if ($urandom_range(0, 9) < 6)
                        add_request(FUNC_APPEND, 0, rand_word());
                    else
                        add_request(FUNC_INSERT, pos_upto(plan_len), rand_word());
                end
            end else if (mode <= 5) begin
                len = $urandom_range(10, 100);
                repeat (len)
                    add_request(FUNC_REMOVE, pos_upto(plan_len), rand_word());
            end else if (mode <= 7) begin
                len = $urandom_range(10, 60);
                repeat (len) begin
                    pick = $urandom_range(0, 9);
                    if (pick < 4)
                        add_request(FUNC_GET, pos_upto(plan_len), rand_word());
                    else if (pick < 6)
                        add_request(FUNC_INSERT, pos_upto(plan_len), rand_word());
                    else if (pick < 8)
                        add_request(FUNC_REMOVE, pos_upto(plan_len), rand_word());
                    else
                        add_request(FUNC_APPEND, pos_upto(MAX_POS), rand_word());
                end
            end else if (mode == 8) begin
                len = $urandom_range(3, 20);
                repeat (len)
                    add_request(FUNC_W'($urandom_range(0, 7)), $urandom_range(0, MAX_POS),
                                $urandom);
            end else begin
                if ($urandom_range(0, 1))
                    add_hold();
                else
                    add_request(FUNC_CLEAR, pos_upto(MAX_POS), rand_word());
            end
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do
            @(negedge i_clk);
        while (!timed_out &&
               !(requests_q.size() == 0 && !start && replies_due.size() == 0));
        if (!timed_out)
            repeat (TAIL_CYCLES) @(negedge i_clk);

        if (!timed_out && mismatches == 0)
            $display("[shifting_insert_remove_list] OK");
        else
            $display("[shifting_insert_remove_list] ERROR");
        $finish;
    end

endmodule
